@@ rtl/nmea_gga_position_parser_defines.svh @@
// Assertion macros shared by the NMEA GGA position parser RTL.
`ifndef NMEA_GGA_POSITION_PARSER_DEFINES_SVH
`define NMEA_GGA_POSITION_PARSER_DEFINES_SVH

// Check that a condition implies an expression in the same cycle.
`define NGP_ASSERT_NOW(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error(msg);

// Check that a condition implies an expression in the next cycle.
`define NGP_ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

@@ rtl/ngp_pkg.sv @@
// Types, constants and helper functions of the NMEA GGA position parser.
`timescale 1ns / 1ps

package ngp_pkg;

    localparam int LINE_CAPACITY_DEFAULT   = 128;
    localparam int FRACTION_DIGITS_DEFAULT = 5;

    // Six pipeline slots from the field snapshot to the output register.
    localparam int PIPE_DEPTH = 6;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_W     = 8'h57;

    // Counted-comma field codes.
    localparam logic [2:0] FIELD_TIME = 3'd0;
    localparam logic [2:0] FIELD_LAT  = 3'd1;
    localparam logic [2:0] FIELD_NS   = 3'd2;
    localparam logic [2:0] FIELD_LON  = 3'd3;
    localparam logic [2:0] FIELD_EW   = 3'd4;
    localparam logic [2:0] FIELD_LAST = 3'd5;

    // Number parse phases.
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // Finish targets of a pipeline transaction.
    localparam logic [1:0] FIN_NONE = 2'd0;
    localparam logic [1:0] FIN_LAT  = 2'd1;
    localparam logic [1:0] FIN_LON  = 2'd2;

    localparam logic [2:0]  PREFIX_LEN   = 3'd6;
    localparam logic [2:0]  FIRST_COUNTED_POS = 3'd7;
    localparam logic [2:0]  UNIT_DIGITS  = 3'd7;
    localparam logic [16:0] WHOLE_MAX    = 17'd99999;
    localparam logic [30:0] MAG_MAX      = 31'd1800000000;
    localparam logic [23:0] UNIT_PER_DEG = 24'd10000000;
    localparam logic [6:0]  MINUTES_PER_DEG_X100 = 7'd100;

    // Reciprocals: whole / 100 as (whole * RECIP_100) >> 24, valid for 17-bit whole;
    // y / 15 as (y * RECIP_15) >> 32, valid for 28-bit y.
    localparam logic [17:0] RECIP_100 = 18'd167773;
    localparam logic [31:0] RECIP_15  = 32'h11111112;

    typedef struct packed {
        logic [1:0] fin;
        logic       line_end;
        logic       emit;
        logic       num_neg;
        logic [7:0] lat_first;
        logic [7:0] lon_first;
        logic       lat_south;
        logic       lon_west;
    } ev_t;

    function automatic logic [23:0] pow10(input logic [3:0] n);
        logic [23:0] r;
        begin
            case (n)
                4'd0:    r = 24'd1;
                4'd1:    r = 24'd10;
                4'd2:    r = 24'd100;
                4'd3:    r = 24'd1000;
                4'd4:    r = 24'd10000;
                4'd5:    r = 24'd100000;
                4'd6:    r = 24'd1000000;
                default: r = 24'd10000000;
            endcase
            return r;
        end
    endfunction

    // Expected character of talker t at prefix position p.
    function automatic logic [7:0] talker_char(input logic [1:0] t, input logic [2:0] p);
        logic [7:0] r;
        begin
            case (p)
                3'd0:    r = 8'h24;
                3'd1:    r = (t == 2'd1) ? 8'h42 : 8'h47;
                3'd2:    r = (t == 2'd0) ? 8'h50 : ((t == 2'd1) ? 8'h44 : 8'h4E);
                3'd3:    r = 8'h47;
                3'd4:    r = 8'h47;
                default: r = 8'h41;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/nmea_gga_position_parser.sv @@
// Top level of the NMEA GGA position parser: line scanner and coordinate pipeline.
`timescale 1ns / 1ps
`include "nmea_gga_position_parser_defines.svh"

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  rx_byte
// output    out        out_valid / out_stall latitude, longitude, lat_hemisphere,
//                                            lon_hemisphere, position_fixed
//
// One byte per cycle is taken while in_stall is low; the scanner registers fold
// each byte into the line state.
// A GGA line end gives its result through six conversion stages (divide by 100,
// scale, divide by 60, saturate) and then the output register.
// Reset clears the line state and the pipeline at once; there is no clearing pass.
// A stalled result holds the whole pipeline and raises in_stall in that cycle.
module nmea_gga_position_parser #(
    parameter int LINE_CAPACITY   = ngp_pkg::LINE_CAPACITY_DEFAULT,
    parameter int FRACTION_DIGITS = ngp_pkg::FRACTION_DIGITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude,
    output logic [7:0]         lat_hemisphere,
    output logic [7:0]         lon_hemisphere,
    output logic               position_fixed
);
    import ngp_pkg::*;

    localparam int POS_W  = $clog2(LINE_CAPACITY);
    localparam int FRAC_W = $clog2(int'(pow10(4'(FRACTION_DIGITS))));
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_CAPACITY - 1);
    localparam logic [2:0]       FRAC_MAX = 3'(FRACTION_DIGITS);

    // ------------------------------------------------------------------
    // Handshake: the pipeline moves whenever the output slot is free or
    // is being emptied in this cycle.
    // ------------------------------------------------------------------
    logic adv;
    logic accept;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // ------------------------------------------------------------------
    // Line scanner state
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [2:0]        alive_reg, alive_next;
    logic              nul_reg, nul_next;
    logic [2:0]        comma_reg, comma_next;
    logic [16:0]       whole_reg, whole_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [2:0]        fc_reg, fc_next;
    logic [1:0]        phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic [7:0]        latd_first_reg, latd_first_next;
    logic [1:0]        latd_len_reg, latd_len_next;
    logic [7:0]        lond_first_reg, lond_first_next;
    logic [1:0]        lond_len_reg, lond_len_next;

    logic        push;
    ev_t         ev_new;
    logic        is_eol;
    logic        is_digit;
    logic        is_space;
    logic        take_int;
    logic [3:0]  digit;
    logic [19:0] whole_grow;
    logic [FRAC_W+3:0] frac_grow;
    logic [1:0]  field_fin;

    assign is_eol   = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign is_space = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
                      (rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);
    assign digit    = rx_byte[3:0];
    assign whole_grow = {3'b000, whole_reg} * 20'd10 + {16'd0, digit};
    assign frac_grow  = {4'b0000, frac_reg} * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);
    assign field_fin  = (comma_reg == FIELD_LAT) ? FIN_LAT :
                        ((comma_reg == FIELD_LON) ? FIN_LON : FIN_NONE);

    always_comb
    begin
        pos_next        = pos_reg;
        alive_next      = alive_reg;
        nul_next        = nul_reg;
        comma_next      = comma_reg;
        whole_next      = whole_reg;
        frac_next       = frac_reg;
        fc_next         = fc_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        latd_first_next = latd_first_reg;
        latd_len_next   = latd_len_reg;
        lond_first_next = lond_first_reg;
        lond_len_next   = lond_len_reg;
        take_int        = 1'b0;

        push             = 1'b0;
        ev_new.fin       = FIN_NONE;
        ev_new.line_end  = 1'b0;
        ev_new.emit      = 1'b0;
        ev_new.num_neg   = neg_reg;
        ev_new.lat_first = latd_first_reg;
        ev_new.lon_first = lond_first_reg;
        ev_new.lat_south = (latd_len_reg == 2'd1) && (latd_first_reg == CHAR_S);
        ev_new.lon_west  = (lond_len_reg == 2'd1) && (lond_first_reg == CHAR_W);

        if (accept)
        begin
            if (is_eol)
            begin
                if (pos_reg != '0)
                begin
                    // Close the line: a talker match emits, any line end clears.
                    push            = 1'b1;
                    ev_new.line_end = 1'b1;
                    ev_new.emit     = (pos_reg >= POS_W'(PREFIX_LEN)) && (alive_reg != 3'b000);
                    ev_new.fin      = ev_new.emit ? field_fin : FIN_NONE;

                    pos_next        = '0;
                    alive_next      = 3'b111;
                    nul_next        = 1'b0;
                    comma_next      = FIELD_TIME;
                    whole_next      = '0;
                    frac_next       = '0;
                    fc_next         = '0;
                    phase_next      = PH_START;
                    neg_next        = 1'b0;
                    latd_first_next = '0;
                    latd_len_next   = '0;
                    lond_first_next = '0;
                    lond_len_next   = '0;
                end
            end
            else if (pos_reg < LAST_POS)
            begin
                pos_next = pos_reg + POS_W'(1);
                if (!nul_reg)
                begin
                    if (pos_reg < POS_W'(PREFIX_LEN))
                    begin
                        for (int t = 0; t < 3; t++)
                        begin
                            if (rx_byte != talker_char(2'(t), pos_reg[2:0]))
                                alive_next[t] = 1'b0;
                        end
                    end

                    if (rx_byte == CHAR_NUL)
                    begin
                        nul_next = 1'b1;
                    end
                    else if ((rx_byte == CHAR_COMMA) &&
                             (pos_reg >= POS_W'(FIRST_COUNTED_POS)))
                    begin
                        // Hand the finished coordinate to the pipeline.
                        push       = (field_fin != FIN_NONE);
                        ev_new.fin = field_fin;
                        if (comma_reg < FIELD_LAST)
                            comma_next = comma_reg + 3'd1;
                        whole_next = '0;
                        frac_next  = '0;
                        fc_next    = '0;
                        phase_next = PH_START;
                        neg_next   = 1'b0;
                    end
                    else
                    begin
                        case (comma_reg) inside
                            FIELD_LAT, FIELD_LON:
                            begin
                                unique case (phase_reg)
                                    PH_START:
                                    begin
                                        if ((rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS))
                                        begin
                                            neg_next   = (rx_byte == CHAR_MINUS);
                                            phase_next = PH_INT;
                                        end
                                        else if (!is_space)
                                        begin
                                            take_int = 1'b1;
                                        end
                                    end
                                    PH_INT:
                                    begin
                                        take_int = 1'b1;
                                    end
                                    PH_FRAC:
                                    begin
                                        if (is_digit)
                                        begin
                                            if (fc_reg < FRAC_MAX)
                                            begin
                                                frac_next = frac_grow[FRAC_W-1:0];
                                                fc_next   = fc_reg + 3'd1;
                                            end
                                        end
                                        else
                                        begin
                                            phase_next = PH_DONE;
                                        end
                                    end
                                    PH_DONE:
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                    default:
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                endcase

                                if (take_int)
                                begin
                                    if (is_digit)
                                    begin
                                        whole_next = (whole_grow > {3'b000, WHOLE_MAX}) ?
                                                     WHOLE_MAX : whole_grow[16:0];
                                        phase_next = PH_INT;
                                    end
                                    else if (rx_byte == CHAR_DOT)
                                    begin
                                        phase_next = PH_FRAC;
                                    end
                                    else
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                end
                            end
                            FIELD_NS:
                            begin
                                if (latd_len_reg == 2'd0)
                                    latd_first_next = rx_byte;
                                if (latd_len_reg < 2'd2)
                                    latd_len_next = latd_len_reg + 2'd1;
                            end
                            FIELD_EW:
                            begin
                                if (lond_len_reg == 2'd0)
                                    lond_first_next = rx_byte;
                                if (lond_len_reg < 2'd2)
                                    lond_len_next = lond_len_reg + 2'd1;
                            end
                            default:
                            begin
                                comma_next = comma_reg;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            alive_reg      <= 3'b111;
            nul_reg        <= 1'b0;
            comma_reg      <= FIELD_TIME;
            whole_reg      <= '0;
            frac_reg       <= '0;
            fc_reg         <= '0;
            phase_reg      <= PH_START;
            neg_reg        <= 1'b0;
            latd_first_reg <= '0;
            latd_len_reg   <= '0;
            lond_first_reg <= '0;
            lond_len_reg   <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            alive_reg      <= alive_next;
            nul_reg        <= nul_next;
            comma_reg      <= comma_next;
            whole_reg      <= whole_next;
            frac_reg       <= frac_next;
            fc_reg         <= fc_next;
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            latd_first_reg <= latd_first_next;
            latd_len_reg   <= latd_len_next;
            lond_first_reg <= lond_first_next;
            lond_len_reg   <= lond_len_next;
        end
    end

    // ------------------------------------------------------------------
    // Transaction tags travel alongside the conversion data, one slot per
    // stage. Valid bits reset; the tag payload does not.
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] ev_vld_reg;
    ev_t                   ev_reg [PIPE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_vld_reg <= '0;
        else if (adv)
            ev_vld_reg <= {ev_vld_reg[PIPE_DEPTH-2:0], push};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ev_reg[0] <= ev_new;
            for (int i = 1; i < PIPE_DEPTH; i++)
                ev_reg[i] <= ev_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Coordinate conversion: D = whole / 100, M = whole % 100 + fraction,
    // magnitude = D * 1e7 + floor(M * 1e7 / 60), saturated.
    // ------------------------------------------------------------------
    logic [16:0]       s1_whole_reg;
    logic [FRAC_W-1:0] s1_frac_reg;
    logic [2:0]        s1_fc_reg;

    logic [34:0]       quot_prod;
    logic [9:0]        s2_quot_next, s2_quot_reg;
    logic [16:0]       s2_whole_reg;
    logic [FRAC_W-1:0] s2_frac_reg;
    logic [2:0]        s2_fc_reg;

    logic [16:0]       quot_x100;
    logic [16:0]       rem_full;
    logic [23:0]       frac_scale;
    logic [FRAC_W+23:0] fracx_full;
    logic [6:0]        s3_rem_next, s3_rem_reg;
    logic [33:0]       s3_deg_next, s3_deg_reg;
    logic [23:0]       s3_fracx_next, s3_fracx_reg;

    logic [29:0]       s4_x_next, s4_x_reg;
    logic [33:0]       s4_deg_reg;

    logic [59:0]       div15_prod;
    logic [23:0]       s5_t_next, s5_t_reg;
    logic [33:0]       s5_deg_reg;

    logic [34:0]       mag_sum;
    logic [30:0]       mag_sat;
    logic signed [31:0] s6_value_next, s6_value_reg;

    // Stage 1: whole / 100 by reciprocal.
    assign quot_prod    = {18'd0, s1_whole_reg} * {17'd0, RECIP_100};
    assign s2_quot_next = quot_prod[33:24];

    // Stage 2: remainder, degrees scaled to 1e-7, fraction scaled to 1e-7 minute.
    assign quot_x100     = {7'd0, s2_quot_reg} * {10'd0, MINUTES_PER_DEG_X100};
    assign rem_full      = s2_whole_reg - quot_x100;
    assign s3_rem_next   = rem_full[6:0];
    assign s3_deg_next   = {24'd0, s2_quot_reg} * {10'd0, UNIT_PER_DEG};
    assign frac_scale    = pow10({1'b0, UNIT_DIGITS - s2_fc_reg});
    assign fracx_full    = {24'd0, s2_frac_reg} * {{FRAC_W{1'b0}}, frac_scale};
    assign s3_fracx_next = fracx_full[23:0];

    // Stage 3: minutes in units of 1e-7 minute.
    assign s4_x_next = {23'd0, s3_rem_reg} * {6'd0, UNIT_PER_DEG} + {6'd0, s3_fracx_reg};

    // Stage 4: divide by 60 as a shift by 2 and a reciprocal of 15.
    assign div15_prod = {32'd0, s4_x_reg[29:2]} * {28'd0, RECIP_15};
    assign s5_t_next  = div15_prod[55:32];

    // Stage 5: add, saturate, apply the number sign.
    assign mag_sum       = {1'b0, s5_deg_reg} + {11'd0, s5_t_reg};
    assign mag_sat       = (mag_sum > {4'd0, MAG_MAX}) ? MAG_MAX : mag_sum[30:0];
    assign s6_value_next = ev_reg[4].num_neg ? -$signed({1'b0, mag_sat}) :
                                               $signed({1'b0, mag_sat});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_whole_reg <= whole_reg;
            s1_frac_reg  <= frac_reg;
            s1_fc_reg    <= fc_reg;

            s2_quot_reg  <= s2_quot_next;
            s2_whole_reg <= s1_whole_reg;
            s2_frac_reg  <= s1_frac_reg;
            s2_fc_reg    <= s1_fc_reg;

            s3_rem_reg   <= s3_rem_next;
            s3_deg_reg   <= s3_deg_next;
            s3_fracx_reg <= s3_fracx_next;

            s4_x_reg     <= s4_x_next;
            s4_deg_reg   <= s3_deg_reg;

            s5_t_reg     <= s5_t_next;
            s5_deg_reg   <= s4_deg_reg;

            s6_value_reg <= s6_value_next;
        end
    end

    // ------------------------------------------------------------------
    // Last stage: keep the field values of the line and form the result.
    // ------------------------------------------------------------------
    logic signed [31:0] lat_value_reg, lat_value_next;
    logic signed [31:0] lon_value_reg, lon_value_next;
    logic signed [31:0] lat_cur, lon_cur;
    logic signed [31:0] lat_out, lon_out;
    logic               emit_now;
    ev_t                ev_last;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] latitude_reg, longitude_reg;
    logic [7:0]         lat_hemi_reg, lon_hemi_reg;
    logic               fixed_reg;

    assign ev_last  = ev_reg[PIPE_DEPTH-1];
    assign lat_cur  = (ev_last.fin == FIN_LAT) ? s6_value_reg : lat_value_reg;
    assign lon_cur  = (ev_last.fin == FIN_LON) ? s6_value_reg : lon_value_reg;
    assign lat_out  = ev_last.lat_south ? -lat_cur : lat_cur;
    assign lon_out  = ev_last.lon_west ? -lon_cur : lon_cur;
    assign emit_now = ev_vld_reg[PIPE_DEPTH-1] && ev_last.line_end && ev_last.emit;

    always_comb
    begin
        lat_value_next = lat_value_reg;
        lon_value_next = lon_value_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = emit_now;
            if (ev_vld_reg[PIPE_DEPTH-1])
            begin
                if (ev_last.line_end)
                begin
                    // Drop the values of the finished line.
                    lat_value_next = '0;
                    lon_value_next = '0;
                end
                else
                begin
                    lat_value_next = lat_cur;
                    lon_value_next = lon_cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_value_reg <= '0;
            lon_value_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lat_value_reg <= lat_value_next;
            lon_value_reg <= lon_value_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit_now)
        begin
            latitude_reg  <= lat_out;
            longitude_reg <= lon_out;
            lat_hemi_reg  <= ev_last.lat_first;
            lon_hemi_reg  <= ev_last.lon_first;
            fixed_reg     <= (lat_out != 32'sd0) && (lon_out != 32'sd0);
        end
    end

    assign out_valid      = out_valid_reg;
    assign latitude       = latitude_reg;
    assign longitude      = longitude_reg;
    assign lat_hemisphere = lat_hemi_reg;
    assign lon_hemisphere = lon_hemi_reg;
    assign position_fixed = fixed_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `NGP_ASSERT_NOW(a_stall_only_when_blocked, in_stall, out_valid && out_stall,
        "input stalled while the output slot is free")
    `NGP_ASSERT_NEXT(a_result_follows_line_end, adv && emit_now, out_valid,
        "GGA line end left the pipeline without a result")
    `NGP_ASSERT_NEXT(a_line_end_clears_scanner, accept && is_eol && (pos_reg != '0),
        (pos_reg == '0) && (comma_reg == FIELD_TIME) && (alive_reg == 3'b111),
        "scanner state not cleared after a line end")

endmodule

@@ tb/nmea_gga_position_parser_tb.sv @@
// Self-checking testbench of the NMEA GGA position parser: directed and random byte streams.
`timescale 1ns / 1ps

module nmea_gga_position_parser_tb;

    import ngp_pkg::*;

    // Block configuration as instantiated below.
    localparam int FRAC_DIGITS = FRACTION_DIGITS_DEFAULT;
    localparam int LINE_CAP    = LINE_CAPACITY_DEFAULT;

    localparam longint unsigned MAG_LIMIT   = 64'd1800000000;
    localparam longint unsigned DEG_UNITS   = 64'd10000000;
    localparam int unsigned     WHOLE_LIMIT = 99999;

    // Run control: traffic phases rotate every PHASE_BYTES accepted bytes.
    localparam int PHASE_BYTES  = 300;
    localparam int HOLD_AT      = 100;
    localparam int HOLD_CYCLES  = 1500;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_BYTES = 860;
    localparam int RANDOM_FIXES = 12;

    // Traffic phases.
    localparam int TRAFFIC_FREE  = 0;
    localparam int TRAFFIC_SEND  = 1;
    localparam int TRAFFIC_RECV  = 2;
    localparam int TRAFFIC_BOTH  = 3;

    typedef struct packed {
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic [7:0]         lat_hemi;
        logic [7:0]         lon_hemi;
        logic               fixed;
    } fix_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [7:0]         lat_hemisphere;
    logic [7:0]         lon_hemisphere;
    logic               position_fixed;

    nmea_gga_position_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .latitude       (latitude),
        .longitude      (longitude),
        .lat_hemisphere (lat_hemisphere),
        .lon_hemisphere (lon_hemisphere),
        .position_fixed (position_fixed)
    );

    // Bytes waiting to be offered, fixes waiting to come out.
    logic [7:0] byte_queue [$];
    fix_t       fix_queue [$];

    int  bytes_in = 0;
    int  cycle_count = 0;
    int  mismatches = 0;
    int  gga_lines = 0;
    bit  byte_taken = 1'b0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    fix_t new_fix;
    fix_t got_fix;

    // ------------------------------------------------------------------
    // Line parser state of the predictor.
    // ------------------------------------------------------------------
    string       talker_name [3] = '{"$GPGGA", "$BDGGA", "$GNGGA"};
    int unsigned ln_pos;
    logic [2:0]  talker_alive;
    logic [2:0]  field_no;
    int unsigned whole_acc;
    int unsigned frac_acc;
    int unsigned frac_cnt;
    logic [1:0]  num_phase;
    bit          num_neg;
    bit          nul_hit;
    logic [7:0]  lat_first;
    logic [7:0]  lon_first;
    int          lat_len;
    int          lon_len;
    logic signed [31:0] lat_units;
    logic signed [31:0] lon_units;

    function automatic longint unsigned ten_to(int n);
        longint unsigned r;
        r = 1;
        for (int i = 0; i < n; i++)
            r = r * 10;
        return r;
    endfunction

    function automatic void clear_number();
        whole_acc = 0;
        frac_acc  = 0;
        frac_cnt  = 0;
        num_phase = PH_START;
        num_neg   = 1'b0;
    endfunction

    function automatic void clear_line();
        ln_pos       = 0;
        talker_alive = 3'b111;
        field_no     = FIELD_TIME;
        clear_number();
        nul_hit   = 1'b0;
        lat_first = 8'h00;
        lon_first = 8'h00;
        lat_len   = 0;
        lon_len   = 0;
        lat_units = 0;
        lon_units = 0;
    endfunction

    // Degrees-and-minutes text to signed 1e-7 degree, magnitude saturated.
    function automatic logic signed [31:0] coord_units();
        longint unsigned scale;
        longint unsigned deg;
        longint unsigned minutes;
        longint unsigned mag;
        int unsigned     fc;
        logic signed [31:0] m;
        scale   = ten_to(FRAC_DIGITS);
        fc      = (frac_cnt <= FRAC_DIGITS) ? frac_cnt : FRAC_DIGITS;
        deg     = whole_acc / 100;
        minutes = longint'(whole_acc % 100) * scale
                + longint'(frac_acc) * ten_to(FRAC_DIGITS - fc);
        mag     = deg * DEG_UNITS + (minutes * DEG_UNITS) / (60 * scale);
        if (mag > MAG_LIMIT)
            mag = MAG_LIMIT;
        m = mag[31:0];
        return num_neg ? -m : m;
    endfunction

    function automatic void close_field();
        if (field_no == FIELD_LAT)
            lat_units = coord_units();
        else if (field_no == FIELD_LON)
            lon_units = coord_units();
    endfunction

    function automatic void feed_number(logic [7:0] c);
        bit is_digit;
        bit is_blank;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
        if (num_phase == PH_START && is_blank) begin
            // skip leading white space
        end
        else if (num_phase == PH_START && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            num_neg   = (c == CHAR_MINUS);
            num_phase = PH_INT;
        end
        else if (num_phase == PH_START || num_phase == PH_INT) begin
            if (is_digit) begin
                whole_acc = whole_acc * 10 + 32'(c - CHAR_ZERO);
                if (whole_acc > WHOLE_LIMIT)
                    whole_acc = WHOLE_LIMIT;
                num_phase = PH_INT;
            end
            else if (c == CHAR_DOT)
                num_phase = PH_FRAC;
            else
                num_phase = PH_DONE;
        end
        else if (num_phase == PH_FRAC) begin
            if (is_digit) begin
                if (frac_cnt < FRAC_DIGITS) begin
                    frac_acc = frac_acc * 10 + 32'(c - CHAR_ZERO);
                    frac_cnt++;
                end
            end
            else
                num_phase = PH_DONE;
        end
    endfunction

    function automatic void parse_char(int unsigned p, logic [7:0] c);
        if (nul_hit)
            return;
        if (p < 6) begin
            for (int t = 0; t < 3; t++)
                if (c != talker_name[t][p])
                    talker_alive[t] = 1'b0;
        end
        if (c == CHAR_NUL) begin
            nul_hit = 1'b1;
            return;
        end
        if (c == CHAR_COMMA && p >= 7) begin
            close_field();
            if (field_no < FIELD_LAST)
                field_no++;
            clear_number();
            return;
        end
        case (field_no)
            FIELD_LAT, FIELD_LON: feed_number(c);
            FIELD_NS:
            begin
                if (lat_len == 0)
                    lat_first = c;
                if (lat_len < 2)
                    lat_len++;
            end
            FIELD_EW:
            begin
                if (lon_len == 0)
                    lon_first = c;
                if (lon_len < 2)
                    lon_len++;
            end
            default: ;
        endcase
    endfunction

    // Fold one byte into the line; return 1 with the fix when a GGA line ends.
    function automatic bit line_fix(logic [7:0] c, output fix_t r);
        logic signed [31:0] la;
        logic signed [31:0] lo;
        r = '0;
        if (c == CHAR_CR || c == CHAR_LF) begin
            if (ln_pos == 0)
                return 1'b0;
            if (ln_pos >= 6 && talker_alive != 3'b000) begin
                close_field();
                la = lat_units;
                lo = lon_units;
                if (lat_len == 1 && lat_first == CHAR_S)
                    la = -la;
                if (lon_len == 1 && lon_first == CHAR_W)
                    lo = -lo;
                r.lat      = la;
                r.lon      = lo;
                r.lat_hemi = lat_first;
                r.lon_hemi = lon_first;
                r.fixed    = (la != 0) && (lo != 0);
                clear_line();
                return 1'b1;
            end
            clear_line();
            return 1'b0;
        end
        if (ln_pos < LINE_CAP - 1) begin
            parse_char(ln_pos, c);
            ln_pos++;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic push_byte(logic [7:0] b);
        byte_queue.push_back(b);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            byte_queue.push_back(s[i]);
    endtask

    task automatic push_digits(int n);
        repeat (n) byte_queue.push_back(8'(CHAR_ZERO + $urandom_range(9)));
    endtask

    task automatic push_eol();
        case ($urandom_range(2))
            0: push_byte(CHAR_CR);
            1: push_byte(CHAR_LF);
            default:
            begin
                push_byte(CHAR_CR);
                push_byte(CHAR_LF);
            end
        endcase
    endtask

    task automatic push_talker();
        push_text(talker_name[$urandom_range(2)]);
    endtask

    // A coordinate with random digits; mostly DDMM.mmmm-like, sometimes odd.
    task automatic push_coord(int int_digits);
        if (chance(10))
            push_byte(chance(50) ? CHAR_SPACE : CHAR_TAB);
        if (chance(10))
            push_byte(chance(50) ? CHAR_MINUS : CHAR_PLUS);
        push_digits(chance(25) ? $urandom_range(7) : int_digits);
        if (chance(80)) begin
            push_byte(CHAR_DOT);
            push_digits(chance(25) ? $urandom_range(9) : $urandom_range(1, 6));
        end
        if (chance(5))
            push_byte(8'($urandom_range(33, 126)));
    endtask

    task automatic push_hemi(logic [7:0] a, logic [7:0] b);
        int r;
        r = $urandom_range(9);
        if (r <= 6)
            push_byte(chance(50) ? a : b);
        else if (r == 8) begin
            push_byte(b);
            push_byte(b);
        end
        else if (r == 9)
            push_byte(8'($urandom_range(255)));
    endtask

    task automatic push_gga_line();
        push_talker();
        push_byte(CHAR_COMMA);
        push_digits($urandom_range(6));
        push_byte(CHAR_COMMA);
        push_coord(4);
        push_byte(CHAR_COMMA);
        push_hemi("N", "S");
        push_byte(CHAR_COMMA);
        push_coord(5);
        push_byte(CHAR_COMMA);
        push_hemi("E", "W");
        if (chance(30))
            push_text(",1,08,0.9,545.4,M,46.9,M,,*47");
        push_eol();
    endtask

    task automatic push_noise_line();
        repeat ($urandom_range(1, 40)) push_byte(8'($urandom_range(255)));
        push_byte(CHAR_CR);
    endtask

    task automatic push_broken_line();
        int k;
        case ($urandom_range(3))
            0:
            begin
                // cut short: later fields missing
                push_talker();
                push_text(",,");
                push_coord(4);
                if (chance(50))
                    push_text(",S");
            end
            1:
            begin
                // damage one character of the talker
                k = $urandom_range(5);
                for (int i = 0; i < 6; i++)
                    push_byte(i == k ? 8'($urandom_range(65, 90)) : talker_name[0][i]);
                push_text(",,4807.1,N,01131.2,E");
            end
            2:
            begin
                // may run past the line capacity
                push_talker();
                push_text(",,");
                push_coord(4);
                push_text(",N,");
                repeat ($urandom_range(100, 140))
                    push_byte(chance(15) ? CHAR_COMMA : 8'(CHAR_ZERO + $urandom_range(9)));
                push_text(",W");
            end
            default:
            begin
                // NUL in the middle, when pushed, ends parsing of the line
                push_talker();
                push_text(",,");
                push_coord(4);
                if (chance(50))
                    push_byte(CHAR_NUL);
                push_text(",S,");
                if (chance(50))
                    push_byte(CHAR_NUL);
                push_coord(5);
                push_text(",W");
            end
        endcase
        push_eol();
    endtask

    task automatic fill_directed();
        // Typical sentence and the other two talkers
        push_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_text("$BDGGA,000000,3150.12345678,S,12128.5,W,1");
        push_byte(CHAR_LF);
        push_text("$GNGGA,,0000.00000,N,00000.0000,E");
        push_byte(CHAR_CR);
        // Largest in-range values and both saturations
        push_text("$GNGGA,,9959.99999,N,18000.00000,E");
        push_byte(CHAR_CR);
        push_text("$GPGGA,,999999.9,S,99999,W");
        push_byte(CHAR_LF);
        // White space, explicit sign, doubled hemisphere letters
        push_text("$GPGGA,, ");
        push_byte(CHAR_TAB);
        push_text("+4807.5,SS,");
        push_byte(CHAR_VT);
        push_byte(CHAR_FF);
        push_text("-01131.25,WW");
        push_byte(CHAR_CR);
        // Negative number with S / W flips back to positive
        push_text("$GPGGA,,-12.5,S,-3,W");
        push_byte(CHAR_CR);
        // Numbers cut off by junk
        push_text("$GPGGA,,12a34,N,1.2.3,E");
        push_byte(CHAR_CR);
        // Missing fields, bare talker, too short, other sentence
        push_text("$GPGGA,,4807");
        push_byte(CHAR_CR);
        push_text("$GPGGA");
        push_byte(CHAR_LF);
        push_text("$GPGG");
        push_byte(CHAR_CR);
        push_text("$GPRMC,123519,A,4807.038,N");
        push_byte(CHAR_CR);
        // Comma at position six is not counted, at seven it is
        push_text("$GPGGA1,4807.0,N,00100.0,E");
        push_byte(CHAR_CR);
        // Empty line ends
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_byte(CHAR_CR);
        // NUL after latitude and inside the talker
        push_text("$GPGGA,,4807.0,N");
        push_byte(CHAR_NUL);
        push_text(",01131.0,E");
        push_byte(CHAR_CR);
        push_text("$GP");
        push_byte(CHAR_NUL);
        push_text("GA,,1.0,N,2.0,E");
        push_byte(CHAR_CR);
        // Line longer than the capacity
        push_text("$GNGGA,,1234.5,N,04500.0,E,");
        repeat (110) push_byte("7");
        push_text(",S");
        push_byte(CHAR_CR);
        // High-bit hemisphere bytes
        push_text("$GPGGA,,1.0,");
        push_byte(8'hC8);
        push_text(",2.0,");
        push_byte(8'hFF);
        push_byte(CHAR_CR);
        // Extra commas, lower case talker, fraction only
        push_text("$GPGGA,,1,N,2,E,,,,,,,,,,");
        push_byte(CHAR_LF);
        push_text("$gpgga,,1,N,2,E");
        push_byte(CHAR_LF);
        push_text("$GPGGA,,.5,N,.99999999,E");
        push_byte(CHAR_CR);
    endtask

    task automatic fill_random();
        int start;
        int kind;
        start = byte_queue.size();
        while (byte_queue.size() - start < RANDOM_BYTES || gga_lines < RANDOM_FIXES) begin
            kind = $urandom_range(9);
            if (kind <= 7) begin
                push_gga_line();
                gga_lines++;
            end
            else if (kind == 8)
                push_noise_line();
            else
                push_broken_line();
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and sequencing.
    // ------------------------------------------------------------------
    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int traffic_phase();
        return (bytes_in / PHASE_BYTES) % 4;
    endfunction

    initial
    begin
        clear_line();
        fill_directed();
        fill_random();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // Wait for every byte to go in, then for every fix to come out.
        while (byte_queue.size() != 0 || in_valid)
            @(negedge clk);
        while (fix_queue.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte driver: hold a stalled transaction, otherwise advance or idle.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!in_valid || byte_taken) begin
                if (byte_queue.size() != 0 &&
                    !((traffic_phase() == TRAFFIC_SEND && chance(86)) ||
                      (traffic_phase() == TRAFFIC_BOTH && chance(12)))) begin
                    in_valid <= 1'b1;
                    rx_byte  <= byte_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off: stall the output while bytes keep coming,
    // so the pipeline fills and pushes back on the input.
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && bytes_in >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver stall per traffic phase, forced high during the hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= (hold_left != 0) ||
                         (traffic_phase() == TRAFFIC_RECV && chance(86)) ||
                         (traffic_phase() == TRAFFIC_BOTH && chance(12));
    end

    // ------------------------------------------------------------------
    // Monitor: check each output transaction, predict each input one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        byte_taken = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall) begin
            if (fix_queue.size() == 0) begin
                $error("unexpected fix: lat %0d lon %0d", latitude, longitude);
                mismatches++;
            end
            else begin
                got_fix = fix_queue.pop_front();
                if (latitude !== got_fix.lat) begin
                    $error("latitude: expected %0d, got %0d", got_fix.lat, latitude);
                    mismatches++;
                end
                if (longitude !== got_fix.lon) begin
                    $error("longitude: expected %0d, got %0d", got_fix.lon, longitude);
                    mismatches++;
                end
                if (lat_hemisphere !== got_fix.lat_hemi) begin
                    $error("lat_hemisphere: expected %0d, got %0d",
                           got_fix.lat_hemi, lat_hemisphere);
                    mismatches++;
                end
                if (lon_hemisphere !== got_fix.lon_hemi) begin
                    $error("lon_hemisphere: expected %0d, got %0d",
                           got_fix.lon_hemi, lon_hemisphere);
                    mismatches++;
                end
                if (position_fixed !== got_fix.fixed) begin
                    $error("position_fixed: expected %0d, got %0d",
                           got_fix.fixed, position_fixed);
                    mismatches++;
                end
            end
        end
        if (byte_taken) begin
            bytes_in++;
            if (line_fix(rx_byte, new_fix))
                fix_queue.push_back(new_fix);
        end
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
